// ===== hw/rtl/msp_gps_pkg.sv =====
`timescale 1ns / 1ps

package msp_gps_pkg;

  // Frame header and command bytes
  localparam logic [7:0] HDR_DOLLAR  = 8'h24;
  localparam logic [7:0] HDR_M       = 8'h4D;
  localparam logic [7:0] HDR_GT      = 8'h3E;
  localparam logic [7:0] CMD_RAW_GPS = 8'd106;

  // Number of payload bytes kept for the GPS decode
  localparam int unsigned GPS_LEN   = 16;
  localparam int unsigned GPS_IDX_W = 4;

  // Depth of the queue between classifier and executor
  localparam int unsigned QUEUE_DEPTH = 2;

  // Kind of a byte that the classifier hands on
  typedef enum logic [1:0] {
    KIND_SIZE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_CSUM = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_GPS_OK    = 2'd0,
    STAT_OTHER_OK  = 2'd1,
    STAT_CSUM_BAD  = 2'd2,
    STAT_GPS_SHORT = 2'd3
  } status_e;

  // One classified byte
  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             data;
    logic [GPS_IDX_W-1:0]   idx;          // payload slot for stored data bytes
    logic                   store;        // data byte lands in the payload store
    logic                   short_frame;  // csum byte of a frame below GPS_LEN
  } op_t;

endpackage

// ===== hw/rtl/msp_gps_front.sv =====
`timescale 1ns / 1ps

module msp_gps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output msp_gps_pkg::op_t   op_o
);

  // Frame phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_M    = 3'd1;
  localparam logic [2:0] PH_GT   = 3'd2;
  localparam logic [2:0] PH_SIZE = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [7:0] size_q, size_d;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;
  logic       xfer;

  assign xfer      = in_valid_i && in_ready_i;
  assign count_inc = count_q + 8'd1;

  // Phase tracking and classification of each transfer
  always_comb begin
    phase_d          = phase_q;
    size_d           = size_q;
    count_d          = count_q;
    push_o           = 1'b0;
    op_o.kind        = msp_gps_pkg::KIND_DATA;
    op_o.data        = rx_byte_i;
    op_o.idx         = count_q[msp_gps_pkg::GPS_IDX_W-1:0];
    op_o.store       = (count_q < 8'(msp_gps_pkg::GPS_LEN));
    op_o.short_frame = (size_q < 8'(msp_gps_pkg::GPS_LEN));
    if (xfer) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == msp_gps_pkg::HDR_DOLLAR) phase_d = PH_M;
        end
        PH_M: begin
          priority if (rx_byte_i == msp_gps_pkg::HDR_M) phase_d = PH_GT;
          else if (rx_byte_i == msp_gps_pkg::HDR_DOLLAR) phase_d = PH_M;
          else phase_d = PH_IDLE;
        end
        PH_GT: begin
          priority if (rx_byte_i == msp_gps_pkg::HDR_GT) phase_d = PH_SIZE;
          else if (rx_byte_i == msp_gps_pkg::HDR_DOLLAR) phase_d = PH_M;
          else phase_d = PH_IDLE;
        end
        PH_SIZE: begin
          size_d    = rx_byte_i;
          count_d   = 8'd0;
          phase_d   = PH_CMD;
          push_o    = 1'b1;
          op_o.kind = msp_gps_pkg::KIND_SIZE;
        end
        PH_CMD: begin
          phase_d   = (size_q == 8'd0) ? PH_CSUM : PH_DATA;
          push_o    = 1'b1;
          op_o.kind = msp_gps_pkg::KIND_CMD;
        end
        PH_DATA: begin
          count_d   = count_inc;
          if (count_inc >= size_q) phase_d = PH_CSUM;
          push_o    = 1'b1;
          op_o.kind = msp_gps_pkg::KIND_DATA;
        end
        PH_CSUM: begin
          phase_d   = PH_IDLE;
          push_o    = 1'b1;
          op_o.kind = msp_gps_pkg::KIND_CSUM;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      size_q  <= 8'd0;
      count_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      size_q  <= size_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/msp_gps_fifo.sv =====
`timescale 1ns / 1ps

module msp_gps_fifo #(
  parameter int unsigned Depth = msp_gps_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  msp_gps_pkg::op_t   push_op_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output msp_gps_pkg::op_t   pop_op_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  msp_gps_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign ready_o  = (count_q != CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_op_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// ===== hw/rtl/msp_gps_back.sv =====
`timescale 1ns / 1ps

module msp_gps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  msp_gps_pkg::op_t    op_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          frame_status_o,
  output logic [7:0]          command_code_o,
  output logic signed [31:0]  latitude_o,
  output logic signed [31:0]  longitude_o,
  output logic signed [15:0]  altitude_o,
  output logic [15:0]         ground_speed_o,
  output logic [15:0]         track_angle_o
);

  logic [7:0]  xor_q;
  logic [7:0]  cmd_q;
  logic [7:0]  payload_q [msp_gps_pkg::GPS_LEN];
  logic        out_valid_q;
  logic        out_free;
  logic        is_csum;
  msp_gps_pkg::status_e status;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_csum  = (op_i.kind == msp_gps_pkg::KIND_CSUM);
  assign pop_o    = valid_i && (!is_csum || out_free);
  assign out_valid_o = out_valid_q;

  // Verdict on the checksum byte
  always_comb begin
    priority if (op_i.data != xor_q) status = msp_gps_pkg::STAT_CSUM_BAD;
    else if (cmd_q != msp_gps_pkg::CMD_RAW_GPS) status = msp_gps_pkg::STAT_OTHER_OK;
    else if (op_i.short_frame) status = msp_gps_pkg::STAT_GPS_SHORT;
    else status = msp_gps_pkg::STAT_GPS_OK;
  end

  // Payload store, written by data bytes only
  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.kind == msp_gps_pkg::KIND_DATA && op_i.store) begin
      payload_q[op_i.idx] <= op_i.data;
    end
  end

  // Running checksum and command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= 8'd0;
      cmd_q <= 8'd0;
    end else if (pop_o) begin
      unique case (op_i.kind)
        msp_gps_pkg::KIND_SIZE: xor_q <= op_i.data;
        msp_gps_pkg::KIND_CMD: begin
          xor_q <= xor_q ^ op_i.data;
          cmd_q <= op_i.data;
        end
        msp_gps_pkg::KIND_DATA: xor_q <= xor_q ^ op_i.data;
        msp_gps_pkg::KIND_CSUM: ;
        default: ;
      endcase
    end
  end

  // Output register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && is_csum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; fields decoded little-endian from the store, zero unless the status is GPS OK
  always_ff @(posedge clk_i) begin
    if (pop_o && is_csum) begin
      frame_status_o <= status;
      command_code_o <= cmd_q;
      if (status == msp_gps_pkg::STAT_GPS_OK) begin
        latitude_o     <= {payload_q[5], payload_q[4], payload_q[3], payload_q[2]};
        longitude_o    <= {payload_q[9], payload_q[8], payload_q[7], payload_q[6]};
        altitude_o     <= {payload_q[11], payload_q[10]};
        ground_speed_o <= {payload_q[13], payload_q[12]};
        track_angle_o  <= {payload_q[15], payload_q[14]};
      end else begin
        latitude_o     <= '0;
        longitude_o    <= '0;
        altitude_o     <= '0;
        ground_speed_o <= '0;
        track_angle_o  <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/msp_response_gps_parser.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// rx        in         in_valid_i/in_ready_o   rx_byte_i
// result    out        out_valid_o/out_ready_i frame_status_o, command_code_o, latitude_o,
//                                              longitude_o, altitude_o, ground_speed_o,
//                                              track_angle_o
// One byte per cycle is taken while in_ready_o is high; out_valid_o rises once the checksum byte
// has passed the queue entry and then the output register. Header bytes stop in the classifier.
// Reset (rst_ni low) returns to waiting for the '$' header; payload store is not cleared.
// A stalled result only holds back checksum bytes; the queue of QueueDepth entries
// absorbs the rest before in_ready_o drops.

module msp_response_gps_parser #(
  parameter int unsigned QueueDepth = msp_gps_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         frame_status_o,
  output logic [7:0]         command_code_o,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] longitude_o,
  output logic signed [15:0] altitude_o,
  output logic [15:0]        ground_speed_o,
  output logic [15:0]        track_angle_o
);

  logic             push;
  msp_gps_pkg::op_t push_op;
  logic             q_valid;
  logic             pop;
  msp_gps_pkg::op_t pop_op;

  // Classifier
  msp_gps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .op_o       (push_op)
  );

  // Queue between classifier and executor
  msp_gps_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .ready_o   (in_ready_o),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  // Executor and result register
  msp_gps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .op_i           (pop_op),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .command_code_o (command_code_o),
    .latitude_o     (latitude_o),
    .longitude_o    (longitude_o),
    .altitude_o     (altitude_o),
    .ground_speed_o (ground_speed_o),
    .track_angle_o  (track_angle_o)
  );

endmodule

// ===== tb/tb_msp_response_gps_parser.sv =====
`timescale 1ns / 1ps

module tb_msp_response_gps_parser;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned ITEM_COUNT   = 1150;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef logic [7:0] byte_q_t[$];

  // Decoded frame report as seen on the result channel
  typedef struct {
    msp_gps_pkg::status_e status;
    logic [7:0]           cmd;
    logic signed [31:0]   lat;
    logic signed [31:0]   lon;
    logic signed [15:0]   alt;
    logic [15:0]          speed;
    logic [15:0]          course;
  } gps_report_t;

  // Deframer phases
  typedef enum {
    WAIT_DOLLAR, WAIT_M, WAIT_GT, GET_SIZE, GET_CMD, GET_DATA, GET_CSUM
  } rx_phase_e;

  // Tracks the frame parser byte by byte and holds the reports still to come
  class gps_report_board;
    rx_phase_e     phase;
    logic [7:0]    size;
    logic [7:0]    cmd;
    logic [7:0]    count;
    logic [7:0]    xsum;
    logic [7:0]    payload[msp_gps_pkg::GPS_LEN];
    gps_report_t   reports[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   per_status[4];

    function new();
      phase   = WAIT_DOLLAR;
      size    = '0;
      cmd     = '0;
      count   = '0;
      xsum    = '0;
      errors  = 0;
      checked = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    // Advance the frame state for one accepted byte
    function void note_byte(logic [7:0] b);
      gps_report_t r;
      case (phase)
        WAIT_DOLLAR: if (b == msp_gps_pkg::HDR_DOLLAR) phase = WAIT_M;
        WAIT_M:      phase = (b == msp_gps_pkg::HDR_M) ? WAIT_GT :
                             (b == msp_gps_pkg::HDR_DOLLAR) ? WAIT_M : WAIT_DOLLAR;
        WAIT_GT:     phase = (b == msp_gps_pkg::HDR_GT) ? GET_SIZE :
                             (b == msp_gps_pkg::HDR_DOLLAR) ? WAIT_M : WAIT_DOLLAR;
        GET_SIZE: begin
          size  = b;
          xsum  = b;
          count = '0;
          phase = GET_CMD;
        end
        GET_CMD: begin
          cmd   = b;
          xsum  = xsum ^ b;
          phase = (size == 8'd0) ? GET_CSUM : GET_DATA;
        end
        GET_DATA: begin
          // bytes past the store still feed the checksum
          if (count < msp_gps_pkg::GPS_LEN) payload[count[3:0]] = b;
          xsum  = xsum ^ b;
          count = count + 8'd1;
          if (count >= size) phase = GET_CSUM;
        end
        GET_CSUM: begin
          phase    = WAIT_DOLLAR;
          r.cmd    = cmd;
          r.lat    = '0;
          r.lon    = '0;
          r.alt    = '0;
          r.speed  = '0;
          r.course = '0;
          if (b != xsum) begin
            r.status = msp_gps_pkg::STAT_CSUM_BAD;
          end else if (cmd != msp_gps_pkg::CMD_RAW_GPS) begin
            r.status = msp_gps_pkg::STAT_OTHER_OK;
          end else if (size < msp_gps_pkg::GPS_LEN) begin
            r.status = msp_gps_pkg::STAT_GPS_SHORT;
          end else begin
            r.status = msp_gps_pkg::STAT_GPS_OK;
            r.lat    = {payload[5], payload[4], payload[3], payload[2]};
            r.lon    = {payload[9], payload[8], payload[7], payload[6]};
            r.alt    = {payload[11], payload[10]};
            r.speed  = {payload[13], payload[12]};
            r.course = {payload[15], payload[14]};
          end
          reports.push_back(r);
        end
        default: phase = WAIT_DOLLAR;
      endcase
    endfunction

    function void diff(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      end
    endfunction

    // Compare one result transfer against the oldest pending report
    function void check_result(logic [1:0] st, logic [7:0] code,
                               logic signed [31:0] lat, logic signed [31:0] lon,
                               logic signed [15:0] alt, logic [15:0] speed,
                               logic [15:0] course);
      gps_report_t r;
      if (reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %h command %h",
                 $time, st, code);
        return;
      end
      r = reports.pop_front();
      checked++;
      per_status[r.status]++;
      diff("frame_status", r.status, st);
      diff("command_code", r.cmd, code);
      diff("latitude", r.lat, lat);
      diff("longitude", r.lon, lon);
      diff("altitude", r.alt, alt);
      diff("ground_speed", r.speed, speed);
      diff("track_angle", r.course, course);
    endfunction

    function int unsigned pending();
      return reports.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         frame_status;
  logic [7:0]         command_code;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [15:0] altitude;
  logic [15:0]        ground_speed;
  logic [15:0]        track_angle;

  gps_report_board board = new();
  bit              calm = 1'b0;
  int unsigned     cycle_count = 0;
  int unsigned     frame_bytes = 0;
  int unsigned     noise_bytes = 0;
  int unsigned     ready_hold = 0;

  msp_response_gps_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_status_o (frame_status),
    .command_code_o (command_code),
    .latitude_o     (latitude),
    .longitude_o    (longitude),
    .altitude_o     (altitude),
    .ground_speed_o (ground_speed),
    .track_angle_o  (track_angle)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one; none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      board.check_result(frame_status, command_code, latitude, longitude,
                         altitude, ground_speed, track_angle);
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // One byte transfer, then an optional idle gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    board.note_byte(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_noise(input logic [7:0] b);
    noise_bytes++;
    send_byte(b);
  endtask

  // Whole response frame; corrupt flips bits of the checksum byte
  task automatic send_frame(input logic [7:0] cmd, input byte_q_t pl, input bit corrupt);
    logic [7:0] x;
    x = 8'(pl.size()) ^ cmd;
    foreach (pl[i]) x ^= pl[i];
    if (corrupt) x ^= 8'($urandom_range(1, 255));
    send_byte(msp_gps_pkg::HDR_DOLLAR);
    send_byte(msp_gps_pkg::HDR_M);
    send_byte(msp_gps_pkg::HDR_GT);
    send_byte(8'(pl.size()));
    send_byte(cmd);
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(x);
    frame_bytes += pl.size() + 6;
  endtask

  // Raw GPS payload: fix, satellites, fields in little-endian order, then extra bytes
  function automatic byte_q_t gps_payload(logic [31:0] lat, logic [31:0] lon,
                                          logic [15:0] alt, logic [15:0] speed,
                                          logic [15:0] course, int unsigned extra);
    byte_q_t q;
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) q.push_back(lat[8*i +: 8]);
    for (int i = 0; i < 4; i++) q.push_back(lon[8*i +: 8]);
    for (int i = 0; i < 2; i++) q.push_back(alt[8*i +: 8]);
    for (int i = 0; i < 2; i++) q.push_back(speed[8*i +: 8]);
    for (int i = 0; i < 2; i++) q.push_back(course[8*i +: 8]);
    repeat (extra) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic byte_q_t random_bytes(int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // Random frame with mostly well-formed content
  task automatic send_random_frame();
    logic [7:0]  cmd;
    int unsigned n;
    int unsigned r;
    bit          corrupt;
    corrupt = ($urandom_range(0, 99) < 12);
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      cmd = msp_gps_pkg::CMD_RAW_GPS;
      n = (r < 70) ? $urandom_range(16, 22) :
          (r < 90) ? $urandom_range(0, 15) : $urandom_range(23, 40);
    end else begin
      cmd = 8'($urandom);
      n = (r < 80) ? $urandom_range(0, 20) :
          (r < 98) ? $urandom_range(21, 64) : $urandom_range(65, 255);
    end
    send_frame(cmd, random_bytes(n), corrupt);
  endtask

  initial begin
    int unsigned r;
    int unsigned k;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray bytes while hunting for the header
    send_noise(8'h00);
    send_noise(8'hFF);
    send_noise(msp_gps_pkg::HDR_M);
    send_noise(msp_gps_pkg::HDR_GT);
    // '$' where 'M' is due, then a wrong byte where 'M' is due
    send_noise(msp_gps_pkg::HDR_DOLLAR);
    send_noise(msp_gps_pkg::HDR_DOLLAR);
    send_noise(8'h58);
    // wrong byte where '>' is due, then '$' where '>' is due
    send_noise(msp_gps_pkg::HDR_DOLLAR);
    send_noise(msp_gps_pkg::HDR_M);
    send_noise(8'h00);
    send_noise(msp_gps_pkg::HDR_DOLLAR);
    send_noise(msp_gps_pkg::HDR_M);
    send_noise(msp_gps_pkg::HDR_DOLLAR);

    // Good GPS frames at the field extremes, one with a longer payload
    send_frame(msp_gps_pkg::CMD_RAW_GPS, gps_payload(32'h8000_0000, 32'h7FFF_FFFF,
               16'h8000, 16'hFFFF, 16'h0000, 0), 1'b0);
    send_frame(msp_gps_pkg::CMD_RAW_GPS, gps_payload(32'h7FFF_FFFF, 32'h8000_0000,
               16'h7FFF, 16'h0000, 16'hFFFF, 4), 1'b0);
    send_frame(msp_gps_pkg::CMD_RAW_GPS, gps_payload(32'hFFFF_FFFF, 32'h0000_0000,
               16'hFFFF, 16'h8000, 16'h7FFF, 0), 1'b0);
    // Short GPS frames, empty payload among them
    send_frame(msp_gps_pkg::CMD_RAW_GPS, random_bytes(15), 1'b0);
    send_frame(msp_gps_pkg::CMD_RAW_GPS, random_bytes(0), 1'b0);
    // Other commands, empty and non-empty
    send_frame(8'h00, random_bytes(0), 1'b0);
    send_frame(8'hFF, random_bytes(3), 1'b0);
    // Bad checksums
    send_frame(msp_gps_pkg::CMD_RAW_GPS, gps_payload($urandom, $urandom, 16'h1234,
               16'h5678, 16'h9ABC, 0), 1'b1);
    send_frame(8'h65, random_bytes(2), 1'b1);

    // Random part: frames with random content, broken headers and line noise
    k = 0;
    while (frame_bytes + noise_bytes < ITEM_COUNT) begin
      calm = ((k % 10) < 2);
      k++;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 5)) send_noise(8'($urandom));
      end else if (r < 14) begin
        send_noise(msp_gps_pkg::HDR_DOLLAR);
        send_noise(($urandom_range(0, 1) == 0) ? msp_gps_pkg::HDR_M : 8'($urandom));
        send_noise(8'($urandom));
      end
      send_random_frame();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding reports, then allow for the pipeline
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d frame bytes and %0d noise bytes, checked %0d reports",
             frame_bytes, noise_bytes, board.checked);
    $display("Reports: gps ok %0d, other ok %0d, bad checksum %0d, short gps %0d",
             board.per_status[msp_gps_pkg::STAT_GPS_OK],
             board.per_status[msp_gps_pkg::STAT_OTHER_OK],
             board.per_status[msp_gps_pkg::STAT_CSUM_BAD],
             board.per_status[msp_gps_pkg::STAT_GPS_SHORT]);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
